// ----- hdl/dpfr_pkg.sv -----
// Package for the demand paging translator with FIFO frame replacement.
// Holds widths, counts, register indexes and the decision struct.
// No dependencies; used by every module of the block.
package dpfr_pkg;

   // item field widths
   localparam int PAGE_W    = 6;
   localparam int NUM_PAGES = 64;
   localparam int OFFSET_W  = 10;
   localparam int FRAME_W   = 6;
   localparam int ADDR_W    = 16;

   // frame slots owned by the job
   localparam int NUM_SLOTS = 4;
   localparam int SLOT_W    = 2;

   // configuration port
   localparam int CSR_IDX_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_SLOT_ZERO  = 4'd0,
      REG_FRAME_SLOT_ONE   = 4'd1,
      REG_FRAME_SLOT_TWO   = 4'd2,
      REG_FRAME_SLOT_THREE = 4'd3
   } csr_index_type;

   localparam logic [FRAME_W-1:0] FRAME_RESET_ZERO  = 6'd5;
   localparam logic [FRAME_W-1:0] FRAME_RESET_ONE   = 6'd8;
   localparam logic [FRAME_W-1:0] FRAME_RESET_TWO   = 6'd9;
   localparam logic [FRAME_W-1:0] FRAME_RESET_THREE = 6'd1;

   // outcome of one lookup, passed from the slot controller to the top
   typedef struct packed {
      logic               fault;
      logic [SLOT_W-1:0]  slot;
      logic               victim_valid;
      logic [PAGE_W-1:0]  evict_page;
      logic               writeback;
      logic [FRAME_W-1:0] frame;
   } decision_type;

endpackage

// ----- hdl/dpfr_page_ram.sv -----
// Page table memory: one slot index per logical page.
// One write port, one read port with registered read data.
// Depends on dpfr_pkg.
module dpfr_page_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [dpfr_pkg::PAGE_W-1:0] wr_addr,
   input  logic [dpfr_pkg::SLOT_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [dpfr_pkg::PAGE_W-1:0] rd_addr,
   output logic [dpfr_pkg::SLOT_W-1:0] rd_data
);

   logic [dpfr_pkg::SLOT_W-1:0] mem [dpfr_pkg::NUM_PAGES];
   logic [dpfr_pkg::SLOT_W-1:0] rd_data_ff;

   // write the new slot of a loaded page
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read old contents; the caller forwards a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dpfr_slot_ctrl.sv -----
// Slot controller: frame registers, slot occupants, dirty marks, FIFO pointer.
// Decides hit, fill or eviction for the item in the lookup stage.
// Depends on dpfr_pkg.
module dpfr_slot_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_wr,
   input  logic [dpfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpfr_pkg::FRAME_W-1:0]   csr_data,
   // item in the lookup stage
   input  logic                           fire,
   input  logic                           store,
   input  logic [dpfr_pkg::PAGE_W-1:0]    page,
   input  logic                           entry_written,
   input  logic [dpfr_pkg::SLOT_W-1:0]    entry_slot,
   output dpfr_pkg::decision_type         decision
);

   logic [dpfr_pkg::FRAME_W-1:0] frame_ff [dpfr_pkg::NUM_SLOTS];
   logic [dpfr_pkg::PAGE_W-1:0]  occ_page_ff [dpfr_pkg::NUM_SLOTS];
   logic [dpfr_pkg::NUM_SLOTS-1:0] occ_valid_ff;
   logic [dpfr_pkg::NUM_SLOTS-1:0] dirty_ff;
   logic [dpfr_pkg::SLOT_W-1:0]  oldest_ff;
   logic [dpfr_pkg::SLOT_W-1:0]  oldest_in;

   logic [dpfr_pkg::NUM_SLOTS-1:0] match;
   logic                         hit;
   logic                         free_found;
   logic [dpfr_pkg::SLOT_W-1:0]  free_slot;
   logic [dpfr_pkg::SLOT_W-1:0]  use_slot;
   logic                         victim;

   // compare every slot against the page; the table's slot picks the one that counts
   always_comb begin
      for (int s = 0; s < dpfr_pkg::NUM_SLOTS; s++) begin
         match[s] = occ_valid_ff[s] && (occ_page_ff[s] == page);
      end
   end

   assign hit = entry_written && match[entry_slot];

   // find the lowest empty slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = dpfr_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
         if (!occ_valid_ff[s]) begin
            free_found = 1'b1;
            free_slot  = dpfr_pkg::SLOT_W'(s);
         end
      end
   end

   assign victim    = !hit && !free_found;
   assign use_slot  = hit ? entry_slot : (free_found ? free_slot : oldest_ff);
   assign oldest_in = oldest_ff + dpfr_pkg::SLOT_W'(1);

   always_comb begin
      decision.fault        = !hit;
      decision.slot         = use_slot;
      decision.victim_valid = victim;
      decision.evict_page   = victim ? occ_page_ff[oldest_ff] : '0;
      decision.writeback    = victim && dirty_ff[oldest_ff];
      decision.frame        = frame_ff[use_slot];
   end

   // hold frame numbers; take writes to known indexes, drop the rest
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff[0] <= dpfr_pkg::FRAME_RESET_ZERO;
         frame_ff[1] <= dpfr_pkg::FRAME_RESET_ONE;
         frame_ff[2] <= dpfr_pkg::FRAME_RESET_TWO;
         frame_ff[3] <= dpfr_pkg::FRAME_RESET_THREE;
      end else if (csr_wr) begin
         case (dpfr_pkg::csr_index_type'(csr_index))
            dpfr_pkg::REG_FRAME_SLOT_ZERO:  frame_ff[0] <= csr_data;
            dpfr_pkg::REG_FRAME_SLOT_ONE:   frame_ff[1] <= csr_data;
            dpfr_pkg::REG_FRAME_SLOT_TWO:   frame_ff[2] <= csr_data;
            dpfr_pkg::REG_FRAME_SLOT_THREE: frame_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // fill or replace a slot on a fault, mark dirty on a store
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_valid_ff <= '0;
         dirty_ff     <= '0;
         oldest_ff    <= '0;
      end else if (fire) begin
         if (!hit) begin
            occ_valid_ff[use_slot] <= 1'b1;
            dirty_ff[use_slot]     <= store;
            if (victim) begin
               oldest_ff <= oldest_in;
            end
         end else if (store) begin
            dirty_ff[use_slot] <= 1'b1;
         end
      end
   end

   // occupant page numbers need no reset: the valid bits guard them
   always_ff @(posedge clock) begin
      if (fire && !hit) begin
         occ_page_ff[use_slot] <= page;
      end
   end

endmodule

// ----- hdl/demand_paging_fifo_replacement_top.sv -----
// Top level of the demand paging translator with FIFO frame replacement.
// Instantiates dpfr_page_ram and dpfr_slot_ctrl; depends on dpfr_pkg.
//
// Usage:
//   req_* carries one access per item: store flag, page number, byte offset.
//   rsp_* returns one result per item: physical address, miss flag, and the
//   evicted page with its write-back flag when a full job had to give one up.
//   csr_* writes the four frame-slot registers (index 0 to 3); other indexes
//   are dropped. csr_ready is always high. Write only while the block is idle.
// Timing:
//   An accepted item waits in the lookup stage; its result is registered in
//   the output register when that register is free, and rsp_valid then rises
//   with the result held until it is taken.
//   Sustained rate is one item per cycle while rsp_stall is low, set by
//   the single page-table read port whose registered data feeds the slot
//   decision; a table write is forwarded to the item read in the same cycle.
// Reset clears every page to absent, empties all slots and restores the
// frame registers. While rsp_stall is high the result holds; the lookup stage
// keeps its item and raises req_stall until the output register frees up.
module demand_paging_fifo_replacement_top (
   input  logic                           clock,
   input  logic                           reset,
   // access items
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [dpfr_pkg::PAGE_W-1:0]    req_page_number,
   input  logic [dpfr_pkg::OFFSET_W-1:0]  req_page_offset,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dpfr_pkg::ADDR_W-1:0]    rsp_physical_address,
   output logic                           rsp_page_miss,
   output logic                           rsp_victim_valid,
   output logic [dpfr_pkg::PAGE_W-1:0]    rsp_evict_page,
   output logic                           rsp_writeback_needed,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dpfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dpfr_pkg::FRAME_W-1:0]   csr_data
);

   // lookup stage
   logic                          s1_valid_ff;
   logic                          s1_store_ff;
   logic [dpfr_pkg::PAGE_W-1:0]   s1_page_ff;
   logic [dpfr_pkg::OFFSET_W-1:0] s1_offset_ff;
   logic                          s1_written_ff;
   logic                          fwd_ff;
   logic [dpfr_pkg::SLOT_W-1:0]   fwd_slot_ff;

   // page-written marks stand in for clearing the table at reset
   logic [dpfr_pkg::NUM_PAGES-1:0] written_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [dpfr_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic                          rsp_fault_ff;
   logic                          rsp_vv_ff;
   logic [dpfr_pkg::PAGE_W-1:0]   rsp_vp_ff;
   logic                          rsp_wb_ff;

   logic                          req_accept;
   logic                          s1_fire;
   logic                          tbl_wr;
   logic [dpfr_pkg::SLOT_W-1:0]   ram_rd_slot;
   logic [dpfr_pkg::SLOT_W-1:0]   entry_slot;
   logic                          entry_written;
   logic [dpfr_pkg::ADDR_W-1:0]   phys_addr;
   logic                          csr_wr;
   dpfr_pkg::decision_type        dec;

   // handshakes
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;
   assign tbl_wr     = s1_fire && dec.fault;
   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid && csr_ready;

   dpfr_page_ram u_page_ram (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (s1_page_ff),
      .wr_data (dec.slot),
      .rd_en   (req_accept),
      .rd_addr (req_page_number),
      .rd_data (ram_rd_slot)
   );

   // take the forwarded slot when the table was written at the read edge
   assign entry_slot    = fwd_ff ? fwd_slot_ff : ram_rd_slot;
   assign entry_written = fwd_ff || s1_written_ff;

   dpfr_slot_ctrl u_slot_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_wr        (csr_wr),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fire          (s1_fire),
      .store         (s1_store_ff),
      .page          (s1_page_ff),
      .entry_written (entry_written),
      .entry_slot    (entry_slot),
      .decision      (dec)
   );

   // frame times page size plus offset, truncated to the address width
   assign phys_addr = (dpfr_pkg::ADDR_W'(dec.frame) << dpfr_pkg::OFFSET_W)
                      + dpfr_pkg::ADDR_W'(s1_offset_ff);

   // advance the lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         written_ff  <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (tbl_wr) begin
            written_ff[s1_page_ff] <= 1'b1;
         end
      end
   end

   // capture the item payload and forwarding info on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_store_ff   <= req_operation;
         s1_page_ff    <= req_page_number;
         s1_offset_ff  <= req_page_offset;
         s1_written_ff <= written_ff[req_page_number];
         fwd_ff        <= tbl_wr && (s1_page_ff == req_page_number);
         fwd_slot_ff   <= dec.slot;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_addr_ff  <= phys_addr;
         rsp_fault_ff <= dec.fault;
         rsp_vv_ff    <= dec.victim_valid;
         rsp_vp_ff    <= dec.evict_page;
         rsp_wb_ff    <= dec.writeback;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_page_miss        = rsp_fault_ff;
   assign rsp_victim_valid     = rsp_vv_ff;
   assign rsp_evict_page       = rsp_vp_ff;
   assign rsp_writeback_needed = rsp_wb_ff;

`ifndef SYNTHESIS
   // a hit never evicts
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !dec.fault |-> !dec.victim_valid)
      else $error("eviction reported on a page hit");

   // a write-back only comes with an eviction
   a_wb_needs_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wb_ff |-> rsp_vv_ff && rsp_fault_ff)
      else $error("write-back flagged without a victim");

   // the table is written only for an item that fires
   a_fwd_only_with_item: assert property (@(posedge clock) disable iff (reset)
      tbl_wr |-> s1_valid_ff && !(rsp_valid_ff && rsp_stall))
      else $error("page table written while the lookup stage is stalled");
`endif

endmodule
